### design/tsk_pkg.sv
// Shared widths, codes and defaults for the Kahn topological sort block.
package tsk_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int MAX_EDGES_DEF    = 256;

   localparam int VTX_W       = 6;
   localparam int CMD_W       = 2;
   localparam int STAT_W      = 3;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;

   localparam logic [VTX_W-1:0] VCOUNT_RESET = 6'd32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_ORDER   = 3'd0,
      ST_OK      = 3'd1,
      ST_CYCLE   = 3'd2,
      ST_ACCEPT  = 3'd3,
      ST_DROP    = 3'd4,
      ST_CLEARED = 3'd5
   } status_type;

endpackage

### design/topological_sort_kahn_top.sv
// Kahn topological sort: edge memory, in-degree and working-degree memories, control FSM.
// Add edge: the edge is stored, then the destination in-degree raised, then accept is sent;
// a bad edge gives drop, clear gives cleared, command 3 no result. Run: copy all MAX_VERTICES
// degrees, then scan; each emitted vertex starts a release pass over the stored edges, then
// a rescan. One command in work at a time; the result register frees the input early.
// Sync reset: edge count, degree valid bits, visited mask, rsp valid clear; vertex_count 32.
module topological_sort_kahn_top #(
   parameter int MAX_VERTICES = tsk_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = tsk_pkg::MAX_EDGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tsk_pkg::REQ_TDATA_W-1:0]  req_tdata,  // src_vertex[5:0], dst_vertex[11:6]
   input  logic [tsk_pkg::CMD_W-1:0]        req_tuser,  // command[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tsk_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // vertex[5:0]
   output logic [tsk_pkg::STAT_W-1:0]       rsp_tuser,  // status[2:0]
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tsk_pkg::VTX_W-1:0]        csr_wdata
);

   localparam int VA_W  = $clog2(MAX_VERTICES + 1);
   localparam int EA_W  = $clog2(MAX_EDGES);
   localparam int EC_W  = $clog2(MAX_EDGES + 1);
   localparam int DEG_W = EC_W;
   localparam int VW    = tsk_pkg::VTX_W;

   typedef enum logic [3:0] {
      IDLE, ADD_WR, COPY_RD, COPY_WR, SCAN_RD, SCAN_CHK,
      REL_RD, REL_CHK, REL_WR, OUT
   } state_type;

   state_type state_ff, ret_ff;

   logic [VW-1:0]             vcount_ff;
   logic [EC_W-1:0]           total_ff;
   logic [MAX_VERTICES:0]     deg_vld_ff;
   logic [MAX_VERTICES:0]     visited_ff;
   logic [VA_W-1:0]           idx_ff;
   logic [VA_W-1:0]           node_ff;
   logic [VA_W-1:0]           dst_ff;
   logic [EC_W-1:0]           eidx_ff;
   logic [VW-1:0]             emitted_ff;
   logic [VW-1:0]             pend_vertex_ff;
   tsk_pkg::status_type       pend_status_ff;
   logic                      pend_last_ff;
   logic                      rsp_valid_ff;
   logic [VW-1:0]             rsp_vertex_ff;
   tsk_pkg::status_type       rsp_status_ff;
   logic                      rsp_last_ff;

   logic [2*VW-1:0]           edge_mem [MAX_EDGES];
   logic [DEG_W-1:0]          deg_mem  [MAX_VERTICES+1];
   logic [DEG_W-1:0]          wdeg_mem [MAX_VERTICES+1];
   logic [2*VW-1:0]           edge_rd_ff;
   logic [DEG_W-1:0]          deg_rd_ff;
   logic                      deg_rd_vld_ff;
   logic [DEG_W-1:0]          wdeg_rd_ff;

   logic                      edge_we, deg_we, wdeg_we;
   logic [EA_W-1:0]           edge_waddr, edge_raddr;
   logic [2*VW-1:0]           edge_wdata;
   logic [VA_W-1:0]           deg_waddr, deg_raddr, wdeg_waddr, wdeg_raddr;
   logic [DEG_W-1:0]          deg_wdata, wdeg_wdata, deg_cur;

   logic [tsk_pkg::CMD_W-1:0] cmd;
   logic [VW-1:0]             src, dst, n_eff, e_src, e_dst;
   logic                      req_acc, out_free, add_ok, rel_hit;

   assign cmd      = req_tuser;
   assign src      = req_tdata[VW-1:0];
   assign dst      = req_tdata[2*VW-1:VW];
   assign e_src    = edge_rd_ff[VW-1:0];
   assign e_dst    = edge_rd_ff[2*VW-1:VW];
   assign n_eff    = (vcount_ff > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vcount_ff;
   assign req_acc  = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign deg_cur  = deg_rd_vld_ff ? deg_rd_ff : '0;
   assign add_ok   = (src != '0) && (dst != '0) && (src <= n_eff) && (dst <= n_eff) &&
                     (total_ff < EC_W'(MAX_EDGES));
   assign rel_hit  = (e_src == VW'(node_ff)) && (e_dst != '0) &&
                     (e_dst <= VW'(MAX_VERTICES)) && !visited_ff[e_dst[VA_W-1:0]];

   assign req_tready = (state_ff == IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tsk_pkg::RSP_TDATA_W'(rsp_vertex_ff);
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      edge_we    = 1'b0;
      edge_waddr = total_ff[EA_W-1:0];
      edge_wdata = {dst, src};
      edge_raddr = eidx_ff[EA_W-1:0];
      deg_we     = 1'b0;
      deg_waddr  = dst_ff;
      deg_wdata  = deg_cur + DEG_W'(1);
      deg_raddr  = idx_ff;
      wdeg_we    = 1'b0;
      wdeg_waddr = idx_ff;
      wdeg_wdata = deg_cur;
      wdeg_raddr = idx_ff;
      case (state_ff)
         IDLE: begin
            deg_raddr = dst[VA_W-1:0];
            if (req_acc && cmd == tsk_pkg::CMD_ADD && add_ok) begin
               edge_we = 1'b1;
            end
         end
         ADD_WR: begin
            deg_we = 1'b1;
         end
         COPY_WR: begin
            wdeg_we = 1'b1;
         end
         REL_CHK: begin
            wdeg_raddr = e_dst[VA_W-1:0];
         end
         REL_WR: begin
            wdeg_waddr = dst_ff;
            wdeg_wdata = wdeg_rd_ff - DEG_W'(1);
            wdeg_we    = (wdeg_rd_ff != '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      edge_rd_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_waddr] <= deg_wdata;
      end
      deg_rd_ff     <= deg_mem[deg_raddr];
      deg_rd_vld_ff <= deg_vld_ff[deg_raddr];
   end

   always_ff @(posedge clock) begin
      if (wdeg_we) begin
         wdeg_mem[wdeg_waddr] <= wdeg_wdata;
      end
      wdeg_rd_ff <= wdeg_mem[wdeg_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         ret_ff       <= IDLE;
         vcount_ff    <= tsk_pkg::VCOUNT_RESET;
         total_ff     <= '0;
         deg_vld_ff   <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            vcount_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_acc) begin
                  pend_vertex_ff <= '0;
                  pend_last_ff   <= 1'b1;
                  ret_ff         <= IDLE;
                  case (cmd)
                     tsk_pkg::CMD_ADD: begin
                        if (add_ok) begin
                           total_ff <= total_ff + EC_W'(1);
                           dst_ff   <= dst[VA_W-1:0];
                           state_ff <= ADD_WR;
                        end else begin
                           pend_status_ff <= tsk_pkg::ST_DROP;
                           state_ff       <= OUT;
                        end
                     end
                     tsk_pkg::CMD_RUN: begin
                        visited_ff <= '0;
                        emitted_ff <= '0;
                        idx_ff     <= VA_W'(1);
                        state_ff   <= COPY_RD;
                     end
                     tsk_pkg::CMD_CLEAR: begin
                        total_ff       <= '0;
                        deg_vld_ff     <= '0;
                        visited_ff     <= '0;
                        pend_status_ff <= tsk_pkg::ST_CLEARED;
                        state_ff       <= OUT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ADD_WR: begin
               deg_vld_ff[dst_ff] <= 1'b1;
               pend_status_ff     <= tsk_pkg::ST_ACCEPT;
               state_ff           <= OUT;
            end
            COPY_RD: begin
               state_ff <= COPY_WR;
            end
            COPY_WR: begin
               if (idx_ff == VA_W'(MAX_VERTICES)) begin
                  idx_ff <= VA_W'(1);
                  if (n_eff == '0) begin
                     pend_vertex_ff <= '0;
                     pend_status_ff <= tsk_pkg::ST_OK;
                     pend_last_ff   <= 1'b1;
                     ret_ff         <= IDLE;
                     state_ff       <= OUT;
                  end else begin
                     state_ff <= SCAN_RD;
                  end
               end else begin
                  idx_ff   <= idx_ff + VA_W'(1);
                  state_ff <= COPY_RD;
               end
            end
            SCAN_RD: begin
               state_ff <= SCAN_CHK;
            end
            SCAN_CHK: begin
               if (!visited_ff[idx_ff] && wdeg_rd_ff == '0) begin
                  visited_ff[idx_ff] <= 1'b1;
                  emitted_ff         <= emitted_ff + VW'(1);
                  node_ff            <= idx_ff;
                  eidx_ff            <= '0;
                  pend_vertex_ff     <= VW'(idx_ff);
                  pend_status_ff     <= tsk_pkg::ST_ORDER;
                  pend_last_ff       <= 1'b0;
                  ret_ff             <= REL_RD;
                  state_ff           <= OUT;
               end else if (VW'(idx_ff) == n_eff) begin
                  pend_vertex_ff <= '0;
                  pend_status_ff <= (emitted_ff == n_eff) ? tsk_pkg::ST_OK : tsk_pkg::ST_CYCLE;
                  pend_last_ff   <= 1'b1;
                  ret_ff         <= IDLE;
                  state_ff       <= OUT;
               end else begin
                  idx_ff   <= idx_ff + VA_W'(1);
                  state_ff <= SCAN_RD;
               end
            end
            REL_RD: begin
               if (eidx_ff == total_ff) begin
                  idx_ff   <= VA_W'(1);
                  state_ff <= SCAN_RD;
               end else begin
                  state_ff <= REL_CHK;
               end
            end
            REL_CHK: begin
               if (rel_hit) begin
                  dst_ff   <= e_dst[VA_W-1:0];
                  state_ff <= REL_WR;
               end else begin
                  eidx_ff  <= eidx_ff + EC_W'(1);
                  state_ff <= REL_RD;
               end
            end
            REL_WR: begin
               eidx_ff  <= eidx_ff + EC_W'(1);
               state_ff <= REL_RD;
            end
            OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_vertex_ff <= pend_vertex_ff;
                  rsp_status_ff <= pend_status_ff;
                  rsp_last_ff   <= pend_last_ff;
                  state_ff      <= ret_ff;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

### design/tsk_chk.sv
// Port-level checker for the topological sort block, with its bind.
module tsk_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tsk_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [tsk_pkg::STAT_W-1:0]       rsp_tuser,
   input logic                             rsp_tlast
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // an order beat never ends a command and names a real vertex
   a_order_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tsk_pkg::ST_ORDER |-> !rsp_tlast && rsp_tdata != '0)
      else $error("bad order beat");

   // every status beat ends its command and carries vertex 0
   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != tsk_pkg::ST_ORDER |-> rsp_tlast && rsp_tdata == '0)
      else $error("bad status beat");

   // no input taken while an order beat is pending: a run is still in progress
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tsk_pkg::ST_ORDER |-> !req_tready)
      else $error("input taken during a run");

endmodule

bind topological_sort_kahn_top tsk_chk u_tsk_chk (.*);

### tb/sv/tb_top.sv
// Testbench for the Kahn topological sort block: directed graph cases, bursts, random graphs.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_V = tsk_pkg::MAX_VERTICES_DEF;
   localparam int MAX_E = tsk_pkg::MAX_EDGES_DEF;
   localparam int VW    = tsk_pkg::VTX_W;
   localparam int CW    = tsk_pkg::CMD_W;
   localparam logic [CW-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam int BURST_ADDS    = 24;
   localparam int ITEM_TARGET   = 160;

   typedef struct {
      logic [VW-1:0]       vertex;
      tsk_pkg::status_type status;
      logic                last;
   } sort_beat_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tsk_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [CW-1:0]                   req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tsk_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [tsk_pkg::STAT_W-1:0]      rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [VW-1:0]                   csr_wdata  = '0;

   // graph mirror
   logic [VW-1:0]    vertex_limit = tsk_pkg::VCOUNT_RESET;
   logic [VW-1:0]    edge_src [MAX_E];
   logic [VW-1:0]    edge_dst [MAX_E];
   int unsigned      edge_total = 0;
   int unsigned      in_deg [MAX_V+1] = '{default: 0};

   sort_beat_type expected_order[$];
   int unsigned   mismatch_count = 0;
   int unsigned   items_sent = 0;
   bit            steady = 1'b0;

   topological_sort_kahn_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #500_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic void queue_beat(input logic [VW-1:0] vertex,
                                      input tsk_pkg::status_type status,
                                      input logic last);
      sort_beat_type beat;
      beat.vertex = vertex;
      beat.status = status;
      beat.last   = last;
      expected_order.insert(expected_order.size(), beat);
   endfunction

   function automatic void predict_graph_response(input logic [CW-1:0] cmd,
                                                  input logic [VW-1:0] src,
                                                  input logic [VW-1:0] dst);
      int unsigned n, node, i, e;
      int unsigned work_deg [MAX_V+1];
      logic [MAX_V:0] visited;
      bit cycle;
      n = (vertex_limit > MAX_V) ? MAX_V : vertex_limit;
      case (cmd)
         tsk_pkg::CMD_ADD: begin
            if (src == 0 || dst == 0 || src > n || dst > n || edge_total >= MAX_E) begin
               queue_beat('0, tsk_pkg::ST_DROP, 1'b1);
            end else begin
               edge_src[edge_total] = src;
               edge_dst[edge_total] = dst;
               edge_total++;
               in_deg[dst]++;
               queue_beat('0, tsk_pkg::ST_ACCEPT, 1'b1);
            end
         end
         tsk_pkg::CMD_RUN: begin
            visited = '0;
            foreach (work_deg[v]) work_deg[v] = in_deg[v];
            node = 1;
            while (node != 0) begin
               node = 0;
               for (i = 1; i <= n && node == 0; i++)
                  if (!visited[i] && work_deg[i] == 0) node = i;
               if (node != 0) begin
                  queue_beat(node[VW-1:0], tsk_pkg::ST_ORDER, 1'b0);
                  visited[node] = 1'b1;
                  for (e = 0; e < edge_total; e++) begin
                     if (edge_src[e] == node && edge_dst[e] != 0 && edge_dst[e] <= MAX_V &&
                         !visited[edge_dst[e]] && work_deg[edge_dst[e]] > 0)
                        work_deg[edge_dst[e]]--;
                  end
               end
            end
            cycle = 1'b0;
            for (i = 1; i <= n; i++)
               if (!visited[i]) cycle = 1'b1;
            if (cycle)
               queue_beat('0, tsk_pkg::ST_CYCLE, 1'b1);
            else
               queue_beat('0, tsk_pkg::ST_OK, 1'b1);
         end
         tsk_pkg::CMD_CLEAR: begin
            edge_total = 0;
            foreach (in_deg[v]) in_deg[v] = 0;
            queue_beat('0, tsk_pkg::ST_CLEARED, 1'b1);
         end
         default: ;
      endcase
   endfunction

   always @(negedge clock)
      rsp_tready <= steady || ($urandom_range(0, 99) >= 38);

   always @(posedge clock) begin
      sort_beat_type exp_beat;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_order.size() == 0) begin
            $error("unexpected result beat: vertex %0d status %0d", rsp_tdata[VW-1:0],
                   rsp_tuser);
            mismatch_count++;
         end else begin
            exp_beat = expected_order.pop_front();
            if (rsp_tdata[VW-1:0] !== exp_beat.vertex) begin
               $error("vertex: expected %0d, got %0d", exp_beat.vertex, rsp_tdata[VW-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser !== exp_beat.status) begin
               $error("status: expected %0d, got %0d", exp_beat.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== exp_beat.last) begin
               $error("last: expected %0d, got %0d", exp_beat.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // called at a falling edge; returns at a falling edge with tvalid still high
   task automatic send_cmd(input logic [CW-1:0] cmd, input logic [VW-1:0] src,
                           input logic [VW-1:0] dst);
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, dst, src};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_graph_response(cmd, src, dst);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (expected_order.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_vertex_count(input logic [VW-1:0] value);
      settle_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      vertex_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_graph();
      send_cmd(tsk_pkg::CMD_RUN, 6'd63, 6'd63);
   endtask

   task automatic test_edge_bounds();
      send_cmd(tsk_pkg::CMD_ADD, 6'd0, 6'd5);
      send_cmd(tsk_pkg::CMD_ADD, 6'd5, 6'd0);
      send_cmd(tsk_pkg::CMD_ADD, 6'd33, 6'd1);
      send_cmd(tsk_pkg::CMD_ADD, 6'd1, 6'd63);
      send_cmd(tsk_pkg::CMD_ADD, 6'd32, 6'd1);
      send_cmd(tsk_pkg::CMD_ADD, 6'd1, 6'd32);
      send_cmd(tsk_pkg::CMD_ADD, 6'd1, 6'd32);
      send_cmd(CMD_UNUSED, 6'd63, 6'd63);
      send_cmd(tsk_pkg::CMD_RUN, 6'd0, 6'd0);
      send_cmd(tsk_pkg::CMD_CLEAR, 6'd42, 6'd21);
   endtask

   task automatic test_zero_vertices();
      write_vertex_count(6'd0);
      send_cmd(tsk_pkg::CMD_ADD, 6'd1, 6'd1);
      send_cmd(tsk_pkg::CMD_RUN, 6'd0, 6'd0);
   endtask

   task automatic test_oversized_count();
      write_vertex_count(6'd63);
      send_cmd(tsk_pkg::CMD_ADD, 6'd32, 6'd5);
      send_cmd(tsk_pkg::CMD_ADD, 6'd33, 6'd1);
      send_cmd(tsk_pkg::CMD_RUN, 6'd0, 6'd0);
      send_cmd(tsk_pkg::CMD_CLEAR, 6'd0, 6'd0);
   endtask

   // vertices above the new count keep their edges but never release anything
   task automatic test_lowered_count();
      write_vertex_count(6'd32);
      send_cmd(tsk_pkg::CMD_ADD, 6'd20, 6'd3);
      send_cmd(tsk_pkg::CMD_ADD, 6'd2, 6'd5);
      send_cmd(tsk_pkg::CMD_ADD, 6'd9, 6'd8);
      send_cmd(tsk_pkg::CMD_ADD, 6'd3, 6'd4);
      write_vertex_count(6'd8);
      send_cmd(tsk_pkg::CMD_RUN, 6'd0, 6'd0);
      send_cmd(tsk_pkg::CMD_CLEAR, 6'd0, 6'd0);
   endtask

   // request valid and response ready held high, no random idle cycles
   task automatic test_burst();
      int unsigned k, s;
      write_vertex_count(6'd12);
      steady = 1'b1;
      send_cmd(tsk_pkg::CMD_CLEAR, 6'd0, 6'd0);
      for (k = 0; k < BURST_ADDS; k++) begin
         s = $urandom_range(1, 11);
         send_cmd(tsk_pkg::CMD_ADD, s[VW-1:0], 6'($urandom_range(s + 1, 12)));
      end
      send_cmd(tsk_pkg::CMD_RUN, 6'd0, 6'd0);
      steady = 1'b0;
      settle_idle();
   endtask

   task automatic test_random_graphs();
      int unsigned adds, k, n, s, d, roll, limit;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 3) begin
            case ($urandom_range(0, 5))
               0:       limit = 1;
               1:       limit = 32;
               2:       limit = 0;
               3:       limit = $urandom_range(33, 63);
               default: limit = $urandom_range(2, 12);
            endcase
            write_vertex_count(limit[VW-1:0]);
         end
         send_cmd(tsk_pkg::CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         n = (vertex_limit > MAX_V) ? MAX_V : vertex_limit;
         adds = $urandom_range(1, 12);
         for (k = 0; k < adds; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70 && n >= 2) begin
               s = $urandom_range(1, n - 1);
               d = $urandom_range(s + 1, n);
               send_cmd(tsk_pkg::CMD_ADD, s[VW-1:0], d[VW-1:0]);
            end else if (roll < 85 && n >= 1) begin
               send_cmd(tsk_pkg::CMD_ADD, 6'($urandom_range(1, n)), 6'($urandom_range(1, n)));
            end else if (roll < 93) begin
               send_cmd(tsk_pkg::CMD_ADD, 6'($urandom_range(0, 63)),
                        6'($urandom_range(0, 63)));
            end else begin
               send_cmd(CMD_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end
         end
         send_cmd(tsk_pkg::CMD_RUN, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_graph();
      test_edge_bounds();
      test_zero_vertices();
      test_oversized_count();
      test_lowered_count();
      test_burst();
      test_random_graphs();
      settle_idle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
design/tsk_pkg.sv
design/topological_sort_kahn_top.sv
design/tsk_chk.sv
tb/sv/tb_top.sv
